### design/psplim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psplim_pkg;

  localparam int LEN_W   = 14;
  localparam int ETYPE_W = 16;
  localparam int ADDR_W  = 32;
  localparam int THR_W   = 32;
  localparam int CNT_W   = 33;

  localparam logic [LEN_W-1:0]   MIN_IPV4_FRAME  = 14'd34;
  localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 32'd1000;
  localparam logic [CNT_W-1:0]   COUNT_MAX       = {CNT_W{1'b1}};

  // One table word: occupancy, blocked mark, packet count and source key.
  typedef struct packed {
    logic              valid;
    logic              blocked;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  // Verdict, drop in the lowest bit.
  typedef struct packed {
    logic table_full_miss;
    logic newly_blocked;
    logic drop;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

### design/psplim_table_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module psplim_table_ram #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire                    clk,
  input  wire                    we,
  input  wire  [AW-1:0]          waddr,
  input  wire psplim_pkg::entry_t wdata,
  input  wire                    re,
  input  wire  [AW-1:0]          raddr,
  output psplim_pkg::entry_t     rdata
);
  import psplim_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read: the data for an address appears in the next cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/psplim_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module psplim_hash #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire [psplim_pkg::ADDR_W-1:0] addr,
  output logic [AW-1:0]                idx
);
  import psplim_pkg::*;

  localparam logic [AW:0] DEPTH_EXT = (AW+1)'(DEPTH);

  logic [AW-1:0] fold;
  logic [AW:0]   fold_ext;

  // XOR-fold the address onto the index width.
  always_comb begin
    fold = '0;
    for (int k = 0; k < ADDR_W; k++) begin
      fold[k % AW] = fold[k % AW] ^ addr[k];
    end
  end

  // The fold is below twice the depth, so one conditional subtract wraps it.
  assign fold_ext = {1'b0, fold};
  assign idx = (fold_ext >= DEPTH_EXT) ? AW'(fold_ext - DEPTH_EXT) : fold;

endmodule

`default_nettype wire

### design/per_source_packet_limiter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-source packet limiter.
// Each request on the s_axis channel carries one received frame's length,
// ethertype and IPv4 source address; exactly one verdict leaves on m_axis
// per request, in order. Short and non-IPv4 frames pass untouched. IPv4
// sources are held in a hashed table with linear probing, one probe per
// cycle from a memory with one read and one write port and registered read.
// An IPv4 frame probes P table slots, where P is 1 for a first-slot hit
// or insert and at most TABLE_ENTRIES when the table is full and the
// source is unknown; short and non-IPv4 frames skip the table.
// One frame is processed at a time: the next is accepted only once the
// verdict of the last has been loaded into the output register.
// The threshold is written on the cfg channel, which is always ready.
// After reset the block sweeps the table clear, one entry per cycle,
// through all TABLE_ENTRIES entries, with s_axis_tready low; cfg writes
// are still taken.
// If the receiver stalls, the verdict waits in the output register; the
// next frame is accepted and looked up meanwhile and waits for that register.
module per_source_packet_limiter_core #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  wire         clk,
  input  wire         rst,
  // s_axis_tdata: frame_length [13:0], source_address [45:14], zero padding
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,
  // s_axis_tuser: ether_type [15:0]
  input  wire  [15:0] s_axis_tuser,
  // m_axis_tdata: drop [0], newly_blocked [1], table_full_miss [2], zeros
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  // Threshold register write channel.
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_data
);
  import psplim_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  // Request fields.
  logic [LEN_W-1:0]   frame_length;
  logic [ETYPE_W-1:0] ether_type;
  logic [ADDR_W-1:0]  source_address;

  assign frame_length   = s_axis_tdata[13:0];
  assign source_address = s_axis_tdata[45:14];
  assign ether_type     = s_axis_tuser;

  // Registers.
  state_t            state;
  state_t            state_next;
  logic [THR_W-1:0]  thr;
  logic [IW-1:0]     clr_idx;
  logic [IW-1:0]     probe_idx;
  logic [IW-1:0]     probe_cnt;
  logic [ADDR_W-1:0] key_addr;
  result_t           res;
  result_t           res_next;

  // Memory access.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  logic          accept;
  logic          relevant;
  logic          out_free;
  logic [IW-1:0] hash_idx;
  logic [IW-1:0] next_idx;
  logic          hit;
  logic          empty;
  logic          last_probe;
  logic          resolved;
  logic [CNT_W-1:0] cnt_inc;
  logic          over;
  logic          res_load;

  assign cfg_ready = 1'b1;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign relevant = (frame_length >= MIN_IPV4_FRAME) && (ether_type == ETHERTYPE_IPV4);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  psplim_hash #(.DEPTH(TABLE_ENTRIES)) u_hash (
    .addr (source_address),
    .idx  (hash_idx)
  );

  psplim_table_ram #(.DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Evaluation of the slot whose data has just come out of the memory.
  // Entries are never removed, so an empty slot ends the probe sequence:
  // the source is not further along, and the table still has room.
  assign hit        = ram_rdata.valid && (ram_rdata.addr == key_addr);
  assign empty      = !ram_rdata.valid;
  assign last_probe = (probe_cnt == LAST_IDX);
  assign resolved   = hit || empty || last_probe;
  assign next_idx   = (probe_idx == LAST_IDX) ? '0 : probe_idx + 1'b1;
  assign cnt_inc    = (ram_rdata.count == COUNT_MAX) ? ram_rdata.count
                                                     : ram_rdata.count + 1'b1;
  assign over       = cnt_inc > {1'b0, thr};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = relevant ? ST_LOOKUP : ST_FINISH;
        end
      end
      ST_LOOKUP: begin
        if (resolved) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: memory port and verdict.
  // The write of an update happens in the resolving lookup cycle, and the
  // next frame cannot issue its read before the finish cycle has passed, so
  // a read never meets an outstanding write to the same slot.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = probe_idx;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = next_idx;
    res_next      = '0;
    res_load      = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_raddr     = hash_idx;
        ram_re        = accept && relevant;
        res_load      = accept;
      end
      ST_LOOKUP: begin
        if (hit) begin
          res_load = 1'b1;
          if (ram_rdata.blocked) begin
            res_next.drop = 1'b1;
          end else begin
            ram_we                 = 1'b1;
            ram_wdata.valid        = 1'b1;
            ram_wdata.blocked      = over;
            ram_wdata.count        = cnt_inc;
            ram_wdata.addr         = key_addr;
            res_next.drop          = over;
            res_next.newly_blocked = over;
          end
        end else if (empty) begin
          res_load        = 1'b1;
          ram_we          = 1'b1;
          ram_wdata.valid = 1'b1;
          ram_wdata.count = CNT_W'(1);
          ram_wdata.addr  = key_addr;
        end else if (last_probe) begin
          res_load                 = 1'b1;
          res_next.table_full_miss = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      thr     <= THRESHOLD_RESET;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
    end
  end

  // Lookup bookkeeping and the pending verdict.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_addr  <= source_address;
      probe_cnt <= '0;
    end else if (state == ST_LOOKUP && ram_re) begin
      probe_cnt <= probe_cnt + 1'b1;
    end
    if (ram_re) begin
      probe_idx <= ram_raddr;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_axis_tdata <= {5'b0, res};
    end
  end

endmodule

`default_nettype wire

### design/psplim_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module psplim_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [47:0] s_axis_tdata,
  input wire [15:0] s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [7:0]  m_axis_tdata,
  input wire        cfg_valid,
  input wire        cfg_ready,
  input wire [31:0] cfg_data
);

  // No verdict is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("verdict valid straight after reset");

  // A stalled verdict holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled verdict changed");

  // One frame at a time: no request is taken in the cycle after one was.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted on consecutive cycles");

  // A newly blocked source is always dropped.
  a_newly_drops: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("newly blocked without drop");

  // A table-full miss passes the frame and blocks nothing.
  a_miss_passes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[0] && !m_axis_tdata[1])
    else $error("table full miss with drop");

endmodule

bind per_source_packet_limiter_core psplim_checker u_psplim_checker (.*);

`default_nettype wire
